FILE: rtl/assert_macros.svh
// assert_macros.svh: shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/hnm_pkg.sv
// ----------------------------------------------------------------------------
// hnm_pkg: shared constants and helpers of the normal map kernel
// Field widths, fixed-point constants and the component to byte mapping.
// ----------------------------------------------------------------------------
package hnm_pkg;

    localparam int HFW          = 16;   // input height field width
    localparam int CFG_W        = 16;   // slope scale register width
    localparam int HEIGHT_BITS  = 16;   // default height precision
    localparam int NUM_FIELDS   = 9;
    localparam int NUM_LANES    = 8;
    localparam int SLOPE_W      = 22;   // Q14 slope magnitude
    localparam int TERM_W       = 15;   // Q14 unit component, up to 1.0
    localparam int BYTE_W       = 8;

    localparam logic [CFG_W-1:0]  SCALE_RESET = 16'd15360;  // 60.0 in 8.8
    localparam logic [TERM_W-1:0] ONE_Q14     = 15'd16384;
    localparam logic [9:0]        DAMP        = 10'd1000;
    localparam logic [7:0]        BYTE_MAX    = 8'd255;

    // signed 2.14 component (magnitude plus sign) to (c+1)/2*255
    function automatic logic [7:0] to_byte(input logic [TERM_W-1:0] q, input logic neg);
        logic [TERM_W-1:0] qs;
        logic [15:0]       v;
        logic [23:0]       p;
        qs = (q > ONE_Q14) ? ONE_Q14 : q;
        v  = neg ? (16'(ONE_Q14) - 16'(qs)) : (16'(ONE_Q14) + 16'(qs));
        p  = 24'(v) * 24'(BYTE_MAX);
        return p[22:15];
    endfunction

endpackage

FILE: rtl/heightmap_normal_map_kernel_core.sv
// ----------------------------------------------------------------------------
// heightmap_normal_map_kernel_core: 3x3 height window to gray and normal texel
// Slave stream: one beat carries a clamped 3x3 window of heights.
// Master stream: one beat carries the gray byte and the RGB normal bytes.
// Config: i_cfg_we writes slope_scale (8.8); write it only while idle.
// Eight slope lanes (four cardinal, four diagonal) run side by side, each
// with a pipelined square root and dividers; a merge stage sums, damps y,
// takes the length and renormalizes.
// Throughput: one beat per clock while s_tready is high. A beat passes the
// input register, the lane pipelines, the merge pipeline and the output
// register; the two square root pipelines and the dividers set its depth.
// Reset clears all valids and loads slope_scale with 60.0.
// When the receiver stalls, an output register plus a skid entry keep
// taking results; once the skid entry fills, the pipeline freezes and
// s_tready drops until the receiver takes a beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heightmap_normal_map_kernel_core #(
    parameter int HEIGHT_BITS = hnm_pkg::HEIGHT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hnm_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // h_center, h_px, h_mx, h_py, h_my, h_pxpy, h_pxmy, h_mxpy, h_mxmy
    input  logic [143:0]               s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // gray_level, normal_x_byte, normal_y_byte, normal_z_byte
    output logic [31:0]                m_tdata
);

    localparam int HB  = HEIGHT_BITS;
    localparam int HFW = hnm_pkg::HFW;
    localparam int NF  = hnm_pkg::NUM_FIELDS;
    localparam int NL  = hnm_pkg::NUM_LANES;
    localparam int TW  = hnm_pkg::TERM_W;
    localparam logic [HB:0] HMAX = {1'b0, {HB{1'b1}}};

    logic [hnm_pkg::CFG_W-1:0] r_scale;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= hnm_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // pipeline advances unless the skid entry holds a beat
    logic en;
    logic r_skid_valid, r_out_valid;
    assign en       = ~r_skid_valid;
    assign s_tready = en;

    logic          r_in_vld;
    logic [HB-1:0] r_h [NF];

    for (genvar f = 0; f < NF; f++) begin : g_field
        logic [HB+HFW-1:0] ext;
        assign ext = {{HB{1'b0}}, s_tdata[f*HFW +: HFW]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_h[f] <= ext[HB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= s_tvalid;
        end
    end

    // gray = floor(c*255 / (2^HB-1)): shift estimate is at most one low
    logic [HB+7:0] g_num;
    logic [7:0]    g_q0;
    logic [HB+8:0] g_rem;
    logic [7:0]    gray;
    assign g_num = (HB+8)'(r_h[0]) * (HB+8)'(hnm_pkg::BYTE_MAX);
    assign g_q0  = g_num[HB+7:HB];
    assign g_rem = {1'b0, g_num} - {1'b0, g_q0, {HB{1'b0}}} + (HB+9)'(g_q0);
    assign gray  = (g_rem >= (HB+9)'(HMAX)) ? (g_q0 + 8'd1) : g_q0;

    // lane pairs (a, b): slope of a - b
    logic [HB-1:0] lane_a [NL];
    logic [HB-1:0] lane_b [NL];
    assign lane_a[0] = r_h[0]; assign lane_b[0] = r_h[1];
    assign lane_a[1] = r_h[2]; assign lane_b[1] = r_h[0];
    assign lane_a[2] = r_h[0]; assign lane_b[2] = r_h[3];
    assign lane_a[3] = r_h[4]; assign lane_b[3] = r_h[0];
    assign lane_a[4] = r_h[0]; assign lane_b[4] = r_h[5];
    assign lane_a[5] = r_h[0]; assign lane_b[5] = r_h[6];
    assign lane_a[6] = r_h[0]; assign lane_b[6] = r_h[7];
    assign lane_a[7] = r_h[0]; assign lane_b[7] = r_h[8];

    logic [NL-1:0] lane_vld;
    logic [TW-1:0] lane_mag [NL];
    logic          lane_neg [NL];
    logic [TW-1:0] lane_up  [NL];
    logic [7:0]    lane_gray [NL];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        hnm_lane #(.HB(HB), .DIAG(i >= 4), .PW(8)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_in_vld),
            .i_a     (lane_a[i]),
            .i_b     (lane_b[i]),
            .i_scale (r_scale),
            .i_pass  (gray),
            .o_valid (lane_vld[i]),
            .o_mag   (lane_mag[i]),
            .o_neg   (lane_neg[i]),
            .o_up    (lane_up[i]),
            .o_pass  (lane_gray[i])
        );
    end

    logic       mg_vld;
    logic [7:0] mg_gray, mg_x, mg_y, mg_z;

    hnm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lane_vld[0]),
        .i_mag   (lane_mag),
        .i_neg   (lane_neg),
        .i_up    (lane_up),
        .i_gray  (lane_gray[0]),
        .o_valid (mg_vld),
        .o_gray  (mg_gray),
        .o_x     (mg_x),
        .o_y     (mg_y),
        .o_z     (mg_z)
    );

    // output register plus one skid entry
    logic        pv, take;
    logic [31:0] pipe_data, r_out_data, r_skid_data;
    assign pv        = mg_vld & en;
    assign take      = r_out_valid & m_tready;
    assign pipe_data = {mg_z, mg_y, mg_x, mg_gray};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_data  <= pipe_data;
                r_out_valid <= pv;
            end
        end else if (pv) begin
            r_skid_data  <= pipe_data;
            r_skid_valid <= 1'b1;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    `ASSERT_ALWAYS(a_lanes_aligned, i_clk, i_rst_n, (lane_vld == '0) || (lane_vld == '1))
    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid)
    `ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, take && r_skid_valid, r_out_valid && !r_skid_valid)

endmodule

FILE: rtl/hnm_isqrt.sv
// ----------------------------------------------------------------------------
// hnm_isqrt: pipelined floor square root
// One result bit per stage, W/2 stages, side data carried alongside.
// ----------------------------------------------------------------------------
module hnm_isqrt #(
    parameter int W  = 46,   // radicand width, even
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [W-1:0]    i_rad,
    input  logic [PW-1:0]   i_pass,
    output logic            o_valid,
    output logic [W/2-1:0]  o_root,
    output logic [PW-1:0]   o_pass
);

    localparam int RW = W / 2;

    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [W-1:0]  r_v    [RW];
    logic [PW-1:0] r_pass [RW];
    logic          r_vld  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [W-1:0]  v_in;
        logic [PW-1:0] pass_in;
        logic          vld_in;
        logic [RW+3:0] trial;
        logic [RW+3:0] t;
        logic [RW+3:0] diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = i_rad;
            assign pass_in = i_pass;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign v_in    = r_v[k-1];
            assign pass_in = r_pass[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign trial = {rem_in, v_in[W-1:W-2]};
        assign t     = {2'b00, root_in, 2'b01};
        assign diff  = trial - t;
        assign ge    = (trial >= t);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[RW+1:0] : trial[RW+1:0];
                r_root[k] <= {root_in[RW-2:0], ge};
                r_v[k]    <= {v_in[W-3:0], 2'b00};
                r_pass[k] <= pass_in;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_pass  = r_pass[RW-1];

endmodule

FILE: rtl/hnm_div.sv
// ----------------------------------------------------------------------------
// hnm_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module hnm_div #(
    parameter int NW = 36,
    parameter int DW = 23,
    parameter int QW = 15,
    parameter int PW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    input  logic [PW-1:0]   i_pass,
    output logic            o_valid,
    output logic [QW-1:0]   o_quo,
    output logic [PW-1:0]   o_pass
);

    localparam int HW = NW - QW;

    logic [HW+DW-1:0] hi_ext;
    assign hi_ext = {{DW{1'b0}}, i_num[NW-1:QW]};

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [QW-1:0] r_lo   [QW];
    logic [DW-1:0] r_den  [QW];
    logic [PW-1:0] r_pass [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [QW-1:0] lo_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pass_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = hi_ext[DW-1:0];
            assign q_in    = '0;
            assign lo_in   = i_num[QW-1:0];
            assign den_in  = i_den;
            assign pass_in = i_pass;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign lo_in   = r_lo[k-1];
            assign den_in  = r_den[k-1];
            assign pass_in = r_pass[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign trial = {rem_in, lo_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_q[k]    <= {q_in[QW-2:0], ge};
                r_lo[k]   <= {lo_in[QW-2:0], 1'b0};
                r_den[k]  <= den_in;
                r_pass[k] <= pass_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_pass  = r_pass[QW-1];

endmodule

FILE: rtl/hnm_lane.sv
// ----------------------------------------------------------------------------
// hnm_lane: one neighbor slope term
// Slope from a height pair, then the normalized horizontal and up parts.
// ----------------------------------------------------------------------------
module hnm_lane #(
    parameter int HB   = hnm_pkg::HEIGHT_BITS,
    parameter bit DIAG = 1'b0,
    parameter int PW   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [HB-1:0]                 i_a,
    input  logic [HB-1:0]                 i_b,
    input  logic [hnm_pkg::CFG_W-1:0]     i_scale,
    input  logic [PW-1:0]                 i_pass,
    output logic                          o_valid,
    output logic [hnm_pkg::TERM_W-1:0]    o_mag,
    output logic                          o_neg,
    output logic [hnm_pkg::TERM_W-1:0]    o_up,
    output logic [PW-1:0]                 o_pass
);

    localparam int SW = hnm_pkg::SLOPE_W;
    localparam int RADW = 46;
    localparam int RW = RADW / 2;
    localparam logic [RADW-1:0] RAD_K = DIAG ? (46'd1 << 30) : (46'd1 << 28);
    localparam logic [29:0]     UP_K  = DIAG ? (30'd1 << 29) : (30'd1 << 28);

    logic            r1_vld, r2_vld, r3_vld;
    logic [HB-1:0]   r1_mag;
    logic            r1_neg, r2_neg, r3_neg;
    logic [PW-1:0]   r1_pass, r2_pass, r3_pass;
    logic [SW-1:0]   r2_s, r3_s;
    logic [2*SW-1:0] r3_sq;

    logic [hnm_pkg::CFG_W+HB-1:0] prod;
    assign prod = (hnm_pkg::CFG_W+HB)'(i_scale) * (hnm_pkg::CFG_W+HB)'(r1_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= (i_a >= i_b) ? (i_a - i_b) : (i_b - i_a);
            r1_neg  <= (i_a < i_b);
            r1_pass <= i_pass;
            r2_s    <= prod[HB+15:HB-6];
            r2_neg  <= r1_neg;
            r2_pass <= r1_pass;
            r3_sq   <= (2*SW)'(r2_s) * (2*SW)'(r2_s);
            r3_s    <= r2_s;
            r3_neg  <= r2_neg;
            r3_pass <= r2_pass;
        end
    end

    logic [RADW-1:0] rad;
    assign rad = (DIAG ? {1'b0, r3_sq, 1'b0} : {2'b00, r3_sq}) + RAD_K;

    logic            sq_vld;
    logic [RW-1:0]   root;
    logic [SW+PW:0]  sq_pass;

    hnm_isqrt #(.W(RADW), .PW(SW+PW+1)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r3_vld),
        .i_rad   (rad),
        .i_pass  ({r3_s, r3_neg, r3_pass}),
        .o_valid (sq_vld),
        .o_root  (root),
        .o_pass  (sq_pass)
    );

    logic vh, vu;

    // horizontal part: S * 2^14 / r
    hnm_div #(.NW(SW+14), .DW(RW), .QW(hnm_pkg::TERM_W), .PW(PW)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (sq_vld),
        .i_num   ({sq_pass[SW+PW:PW+1], 14'd0}),
        .i_den   (root),
        .i_pass  (sq_pass[PW-1:0]),
        .o_valid (vh),
        .o_quo   (o_mag),
        .o_pass  (o_pass)
    );

    // up part: constant / r
    hnm_div #(.NW(30), .DW(RW), .QW(hnm_pkg::TERM_W), .PW(1)) u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (sq_vld),
        .i_num   (UP_K),
        .i_den   (root),
        .i_pass  (sq_pass[PW]),
        .o_valid (vu),
        .o_quo   (o_up),
        .o_pass  (o_neg)
    );

    assign o_valid = vh & vu;

endmodule

FILE: rtl/hnm_merge.sv
// ----------------------------------------------------------------------------
// hnm_merge: combine lane terms and renormalize
// Weighted sum, y damping, length, per-component division and byte mapping.
// ----------------------------------------------------------------------------
module hnm_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [hnm_pkg::TERM_W-1:0]    i_mag [hnm_pkg::NUM_LANES],
    input  logic                          i_neg [hnm_pkg::NUM_LANES],
    input  logic [hnm_pkg::TERM_W-1:0]    i_up  [hnm_pkg::NUM_LANES],
    input  logic [7:0]                    i_gray,
    output logic                          o_valid,
    output logic [7:0]                    o_gray,
    output logic [7:0]                    o_x,
    output logic [7:0]                    o_y,
    output logic [7:0]                    o_z
);

    localparam int NL = hnm_pkg::NUM_LANES;
    localparam int TW = hnm_pkg::TERM_W;
    localparam int MW = 28;        // damped component magnitude
    localparam int RADW = 58;
    localparam int LW = RADW / 2;

    // lanes 0,1 feed x, lanes 2,3 feed z, lanes 4..7 are diagonals
    logic signed [20:0] t [NL];
    logic        [20:0] u [NL];
    for (genvar i = 0; i < NL; i++) begin : g_term
        assign t[i] = i_neg[i] ? -$signed({6'd0, i_mag[i]}) : $signed({6'd0, i_mag[i]});
        assign u[i] = {6'd0, i_up[i]};
    end

    logic signed [20:0] card_x, card_z, diag_h, sum_x, sum_z;
    logic        [20:0] card_u, diag_u, sum_y;
    assign card_x = t[0] + t[1];
    assign card_z = t[2] + t[3];
    assign diag_h = t[4] + t[5] + t[6] + t[7];
    assign card_u = u[0] + u[1] + u[2] + u[3];
    assign diag_u = u[4] + u[5] + u[6] + u[7];
    assign sum_x  = (card_x <<< 1) + card_x + (diag_h <<< 1);
    assign sum_z  = (card_z <<< 1) + card_z + (diag_h <<< 1);
    assign sum_y  = (card_u << 1) + card_u + (diag_u << 1);

    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [20:0] r1_sx, r1_sz;
    logic        [20:0] r1_sy;
    logic [7:0]         r1_gray, r2_gray, r3_gray, r4_gray;
    logic [MW-1:0]      r2_mx, r2_my, r2_mz, r3_mx, r3_my, r3_mz, r4_mx, r4_my, r4_mz;
    logic               r2_nx, r2_nz, r3_nx, r3_nz, r4_nx, r4_nz;
    logic [2*MW-1:0]    r3_qx, r3_qy, r3_qz;
    logic [RADW-1:0]    r4_rad;

    logic [20:0] ax, az;
    logic [30:0] px, pz;
    assign ax = r1_sx[20] ? 21'(-r1_sx) : 21'(r1_sx);
    assign az = r1_sz[20] ? 21'(-r1_sz) : 21'(r1_sz);
    assign px = 31'(ax) * 31'(hnm_pkg::DAMP);
    assign pz = 31'(az) * 31'(hnm_pkg::DAMP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sx   <= sum_x;
            r1_sz   <= sum_z;
            r1_sy   <= sum_y;
            r1_gray <= i_gray;
            // x and z scaled by 1000 instead of damping y
            r2_mx   <= px[MW-1:0];
            r2_mz   <= pz[MW-1:0];
            r2_my   <= MW'(r1_sy);
            r2_nx   <= r1_sx[20];
            r2_nz   <= r1_sz[20];
            r2_gray <= r1_gray;
            r3_qx   <= (2*MW)'(r2_mx) * (2*MW)'(r2_mx);
            r3_qy   <= (2*MW)'(r2_my) * (2*MW)'(r2_my);
            r3_qz   <= (2*MW)'(r2_mz) * (2*MW)'(r2_mz);
            r3_mx   <= r2_mx;
            r3_my   <= r2_my;
            r3_mz   <= r2_mz;
            r3_nx   <= r2_nx;
            r3_nz   <= r2_nz;
            r3_gray <= r2_gray;
            r4_rad  <= RADW'(r3_qx) + RADW'(r3_qy) + RADW'(r3_qz);
            r4_mx   <= r3_mx;
            r4_my   <= r3_my;
            r4_mz   <= r3_mz;
            r4_nx   <= r3_nx;
            r4_nz   <= r3_nz;
            r4_gray <= r3_gray;
        end
    end

    localparam int SPW = 3*MW + 10;
    logic           sq_vld;
    logic [LW-1:0]  len, den;
    logic [SPW-1:0] sq_pass;

    hnm_isqrt #(.W(RADW), .PW(SPW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_vld),
        .i_rad   (r4_rad),
        .i_pass  ({r4_mx, r4_my, r4_mz, r4_nx, r4_nz, r4_gray}),
        .o_valid (sq_vld),
        .o_root  (len),
        .o_pass  (sq_pass)
    );

    assign den = (len == '0) ? LW'(1) : len;

    logic [MW-1:0] sq_mx, sq_my, sq_mz;
    logic          sq_nx, sq_nz;
    logic [7:0]    sq_gray;
    assign {sq_mx, sq_my, sq_mz, sq_nx, sq_nz, sq_gray} = sq_pass;

    logic          vx, vy, vz, d_nx, d_nz;
    logic [TW-1:0] qx, qy, qz;
    logic [7:0]    d_gray;

    hnm_div #(.NW(MW+14), .DW(LW), .QW(TW), .PW(1)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_valid(sq_vld),
        .i_num({sq_mx, 14'd0}), .i_den(den), .i_pass(sq_nx),
        .o_valid(vx), .o_quo(qx), .o_pass(d_nx)
    );

    hnm_div #(.NW(MW+14), .DW(LW), .QW(TW), .PW(8)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_valid(sq_vld),
        .i_num({sq_my, 14'd0}), .i_den(den), .i_pass(sq_gray),
        .o_valid(vy), .o_quo(qy), .o_pass(d_gray)
    );

    hnm_div #(.NW(MW+14), .DW(LW), .QW(TW), .PW(1)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_valid(sq_vld),
        .i_num({sq_mz, 14'd0}), .i_den(den), .i_pass(sq_nz),
        .o_valid(vz), .o_quo(qz), .o_pass(d_nz)
    );

    logic r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= vx & vy & vz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= hnm_pkg::to_byte(qx, d_nx);
            o_y    <= hnm_pkg::to_byte(qy, 1'b0);
            o_z    <= hnm_pkg::to_byte(qz, d_nz);
            o_gray <= d_gray;
        end
    end

    assign o_valid = r_vld;

endmodule
